@@ sv/bsd_pkg.sv @@
// Shared types, codes and constants for the bounded shift deque.
package bsd_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int KIND_W    = 3;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 4;
  localparam int OCC_W     = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_DUMP       = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;
    logic dump_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic dump_last;
  } sts_t;

endpackage

@@ sv/bsd_ctrl.sv @@
// Controller state machine: accepts items and sequences dumps.
module bsd_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bsd_pkg::KIND_W-1:0]  in_kind,
  input  bsd_pkg::sts_t               sts,
  output logic                        busy,
  output bsd_pkg::cmd_t               cmd
);

  bsd_pkg::state_t state_r;
  bsd_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsd_pkg::ST_IDLE: begin
        if (start && (in_kind == bsd_pkg::KIND_DUMP) && !sts.empty) begin
          state_nxt = bsd_pkg::ST_DUMP;
        end
      end
      bsd_pkg::ST_DUMP: begin
        if (sts.dump_last) begin
          state_nxt = bsd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bsd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy          = 1'b0;
    cmd.exec      = 1'b0;
    cmd.dump_step = 1'b0;
    case (state_r)
      bsd_pkg::ST_IDLE: begin
        cmd.exec = start;
      end
      bsd_pkg::ST_DUMP: begin
        busy          = 1'b1;
        cmd.dump_step = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

@@ sv/bsd_datapath.sv @@
// Datapath: entry shift array, count, dump index and result registers.
module bsd_datapath #(
  parameter int DEPTH = bsd_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bsd_pkg::cmd_t                      cmd,
  input  logic [bsd_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [bsd_pkg::VALUE_W-1:0] in_value,
  output bsd_pkg::sts_t                      sts,
  output logic                               out_valid,
  output logic [bsd_pkg::STATUS_W-1:0]       out_status,
  output logic signed [bsd_pkg::VALUE_W-1:0] out_element,
  output logic [bsd_pkg::POS_W-1:0]          out_position,
  output logic [bsd_pkg::OCC_W-1:0]          out_occupancy,
  output logic                               out_final_result
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic signed [bsd_pkg::VALUE_W-1:0] entries_r   [DEPTH];
  logic signed [bsd_pkg::VALUE_W-1:0] entries_nxt [DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic                               valid_r, valid_nxt;
  bsd_pkg::status_t                   status_r, status_nxt;
  logic signed [bsd_pkg::VALUE_W-1:0] element_r, element_nxt;
  logic [bsd_pkg::POS_W-1:0]          position_r, position_nxt;
  logic [bsd_pkg::OCC_W-1:0]          occ_r, occ_nxt;
  logic                               final_r, final_nxt;

  logic [CNT_W-1:0]                   last_cnt;
  logic [IDX_W-1:0]                   rd_addr;
  logic signed [bsd_pkg::VALUE_W-1:0] rd_data;

  // One read port: the dump walks it by index, a back pop reads the last entry.
  assign last_cnt = count_r - CNT_W'(1);
  assign rd_addr  = cmd.dump_step ? idx_r : last_cnt[IDX_W-1:0];
  assign rd_data  = entries_r[rd_addr];

  assign sts.empty     = (count_r == '0);
  assign sts.full      = (count_r == CNT_W'(DEPTH));
  assign sts.dump_last = (CNT_W'(idx_r) == last_cnt);

  always_comb begin
    entries_nxt  = entries_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    valid_nxt    = 1'b0;
    status_nxt   = bsd_pkg::STATUS_DONE;
    element_nxt  = '0;
    position_nxt = '0;
    final_nxt    = 1'b1;
    if (cmd.dump_step) begin
      valid_nxt    = 1'b1;
      element_nxt  = rd_data;
      position_nxt = bsd_pkg::POS_W'(idx_r);
      final_nxt    = sts.dump_last;
      idx_nxt      = idx_r + IDX_W'(1);
    end else if (cmd.exec) begin
      valid_nxt = 1'b1;
      case (bsd_pkg::kind_t'(in_kind))
        bsd_pkg::KIND_PUSH_FRONT: begin
          if (sts.full) begin
            status_nxt = bsd_pkg::STATUS_FULL;
          end else begin
            entries_nxt[0] = in_value;
            for (int i = 1; i < DEPTH; i++) begin
              entries_nxt[i] = entries_r[i-1];
            end
            count_nxt = count_r + CNT_W'(1);
          end
        end
        bsd_pkg::KIND_PUSH_BACK: begin
          if (sts.full) begin
            status_nxt = bsd_pkg::STATUS_FULL;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              if (count_r == CNT_W'(i)) begin
                entries_nxt[i] = in_value;
              end
            end
            count_nxt = count_r + CNT_W'(1);
          end
        end
        bsd_pkg::KIND_POP_FRONT: begin
          if (sts.empty) begin
            status_nxt = bsd_pkg::STATUS_EMPTY;
          end else begin
            element_nxt = entries_r[0];
            // Cells above the count hold nothing that is ever read.
            for (int i = 0; i < DEPTH - 1; i++) begin
              entries_nxt[i] = entries_r[i+1];
            end
            count_nxt = last_cnt;
          end
        end
        bsd_pkg::KIND_POP_BACK: begin
          if (sts.empty) begin
            status_nxt = bsd_pkg::STATUS_EMPTY;
          end else begin
            element_nxt = rd_data;
            count_nxt   = last_cnt;
          end
        end
        bsd_pkg::KIND_DUMP: begin
          if (sts.empty) begin
            status_nxt = bsd_pkg::STATUS_EMPTY;
          end else begin
            // The entries follow one a cycle; nothing is reported now.
            valid_nxt = 1'b0;
            idx_nxt   = '0;
          end
        end
        default: status_nxt = bsd_pkg::STATUS_DONE;
      endcase
    end
    occ_nxt = bsd_pkg::OCC_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entries_r  <= entries_nxt;
    idx_r      <= idx_nxt;
    status_r   <= status_nxt;
    element_r  <= element_nxt;
    position_r <= position_nxt;
    occ_r      <= occ_nxt;
    final_r    <= final_nxt;
  end

  assign out_valid        = valid_r;
  assign out_status       = status_r;
  assign out_element      = element_r;
  assign out_position     = position_r;
  assign out_occupancy    = occ_r;
  assign out_final_result = final_r;

endmodule

@@ sv/bounded_shift_deque.sv @@
// Top level of the bounded shift deque: controller plus datapath.
//
//   channel  ports                              handshake
//   input    in_kind, in_value                  start high, busy low
//   result   out_status, out_element,           out_valid, one cycle,
//            out_position, out_occupancy,       no stall
//            out_final_result
//
// A push, a pop, a refused dump or an unknown kind gives one result in the
// cycle after the item is accepted, and the next item can be taken at once.
// A dump of N entries holds busy while it walks the entries and gives its N
// results on consecutive cycles: the accepting cycle only clears the dump
// index, then the single read port on the entry array gives one entry per
// cycle, and each entry passes through the result registers.
// Reset clears the count and the controller; entry contents are not cleared.
// Results cannot be stalled by the receiver.
module bounded_shift_deque #(
  parameter int DEPTH = bsd_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [bsd_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [bsd_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  output logic [bsd_pkg::STATUS_W-1:0]       out_status,
  output logic signed [bsd_pkg::VALUE_W-1:0] out_element,
  output logic [bsd_pkg::POS_W-1:0]          out_position,
  output logic [bsd_pkg::OCC_W-1:0]          out_occupancy,
  output logic                               out_final_result
);

  bsd_pkg::cmd_t cmd;
  bsd_pkg::sts_t sts;

  bsd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  bsd_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_kind          (in_kind),
    .in_value         (in_value),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_element      (out_element),
    .out_position     (out_position),
    .out_occupancy    (out_occupancy),
    .out_final_result (out_final_result)
  );

endmodule

@@ sv/bsd_checker.sv @@
// Port-level checker for the bounded shift deque, bound to the top level.
module bsd_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic [bsd_pkg::STATUS_W-1:0]       out_status,
  input logic signed [bsd_pkg::VALUE_W-1:0] out_element,
  input logic [bsd_pkg::POS_W-1:0]          out_position,
  input logic [bsd_pkg::OCC_W-1:0]          out_occupancy,
  input logic                               out_final_result
);

  // An accepted item either reports at once or starts a dump.
  a_accept_answered: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("accepted item produced neither a result nor a dump");

  // A dump result that is not the last one means the dump is still running.
  a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_result |-> busy)
    else $error("non-final dump result while not busy");

  // Dump results follow each other with rising positions and equal occupancy.
  a_dump_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_result |=> out_valid &&
      (out_position == bsd_pkg::POS_W'($past(out_position) + 1'b1)) &&
      (out_occupancy == $past(out_occupancy)))
    else $error("dump results out of order");

  // A refused item carries no element and no position.
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != bsd_pkg::STATUS_DONE) |->
      (out_element == '0) && (out_position == '0) && out_final_result)
    else $error("refused item carries data");

endmodule

bind bounded_shift_deque bsd_checker u_bsd_checker (.*);
